>>> design/lrast_pkg.sv
// ----------------------------------------------------------------------------
// lrast_pkg
// Shared widths, command type and queue sizing for the line rasterizer.
// ----------------------------------------------------------------------------
package lrast_pkg;

  localparam int COORD_BITS  = 11;
  localparam int COLOR_BITS  = 16;
  localparam int ERR_BITS    = COORD_BITS + 3;
  localparam int TWICE_BITS  = COORD_BITS + 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  // One classified request: a line load with ordered endpoints, or a step tick
  typedef struct packed {
    logic   start;
    coord_t xa;
    coord_t ya;
    coord_t xb;
    coord_t yb;
    coord_t dx;
    coord_t dy;
    logic   y_desc;
    color_t color;
  } lrast_cmd_t;

endpackage

>>> design/lrast_front.sv
// ----------------------------------------------------------------------------
// lrast_front
// Classifies each request and orders line endpoints so that x increases,
// producing the spans and the y direction for the stepper.
// ----------------------------------------------------------------------------
module lrast_front import lrast_pkg::*; (
  input  logic       start_req,
  input  coord_t     x_begin,
  input  coord_t     y_begin,
  input  coord_t     x_finish,
  input  coord_t     y_finish,
  input  color_t     line_color,
  output lrast_cmd_t cmd
);

  logic   swap;
  coord_t xa, ya, xb, yb;

  // Order endpoints: x ascending, then y ascending for vertical lines
  assign swap = (x_begin > x_finish) || ((x_begin == x_finish) && (y_begin > y_finish));
  assign xa   = swap ? x_finish : x_begin;
  assign ya   = swap ? y_finish : y_begin;
  assign xb   = swap ? x_begin  : x_finish;
  assign yb   = swap ? y_begin  : y_finish;

  // Build the request with absolute spans
  always_comb begin
    cmd.start  = start_req;
    cmd.xa     = xa;
    cmd.ya     = ya;
    cmd.xb     = xb;
    cmd.yb     = yb;
    cmd.dx     = xb - xa;
    cmd.y_desc = (yb < ya);
    cmd.dy     = (yb < ya) ? (ya - yb) : (yb - ya);
    cmd.color  = line_color;
  end

endmodule

>>> design/lrast_queue.sv
// ----------------------------------------------------------------------------
// lrast_queue
// Short request queue that decouples the front classifier from the stepper.
// ----------------------------------------------------------------------------
module lrast_queue import lrast_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  lrast_cmd_t push_data,
  output logic       not_full,
  input  logic       pop,
  output logic       not_empty,
  output lrast_cmd_t pop_data
);

  lrast_cmd_t             mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QPTR_BITS:0]     count;

  assign not_full  = (count != (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // Store incoming requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/lrast_back.sv
// ----------------------------------------------------------------------------
// lrast_back
// Bresenham stepper: loads line setup, emits one pixel per step request
// while a line is active, into a registered output stage.
// ----------------------------------------------------------------------------
module lrast_back import lrast_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  lrast_cmd_t cmd,
  output logic       cmd_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output coord_t     pixel_x,
  output coord_t     pixel_y,
  output color_t     pixel_color,
  output logic       last_pixel
);

  logic                        line_active;
  coord_t                      pos_x, pos_y, end_x, end_y;
  logic signed [ERR_BITS-1:0]  decision_term;
  logic [TWICE_BITS-1:0]       twice_minor;
  logic signed [ERR_BITS-1:0]  twice_minor_less_major;
  logic                        steep_major_y;
  logic                        y_descending;
  color_t                      held_color;

  logic   emit, load, is_last, d_neg, x_inc, y_step;
  logic   ld_steep;
  coord_t ld_major, ld_minor;
  coord_t pos_y_next;

  // Pop loads and idle ticks freely; a pixel needs room in the output stage
  assign cmd_pop = cmd_valid && (cmd.start || !line_active || !out_valid || out_ready);
  assign load    = cmd_pop && cmd.start;
  assign emit    = cmd_pop && !cmd.start && line_active;

  // Line setup from the ordered spans
  assign ld_steep = (cmd.dy > cmd.dx);
  assign ld_major = ld_steep ? cmd.dy : cmd.dx;
  assign ld_minor = ld_steep ? cmd.dx : cmd.dy;

  // Step decision
  assign is_last    = steep_major_y ? (pos_y == end_y) : (pos_x == end_x);
  assign d_neg      = decision_term[ERR_BITS-1];
  assign x_inc      = !steep_major_y || !d_neg;
  assign y_step     = steep_major_y || !d_neg;
  assign pos_y_next = y_descending ? (pos_y - 1'b1) : (pos_y + 1'b1);

  // Hold line state and advance it on each emitted pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (load) begin
      line_active <= 1'b1;
    end else if (emit && is_last) begin
      line_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pos_x                  <= cmd.xa;
      pos_y                  <= cmd.ya;
      end_x                  <= cmd.xb;
      end_y                  <= cmd.yb;
      steep_major_y          <= ld_steep;
      y_descending           <= cmd.y_desc;
      held_color             <= cmd.color;
      twice_minor            <= TWICE_BITS'({ld_minor, 1'b0});
      twice_minor_less_major <= $signed({2'b00, ld_minor, 1'b0})
                                - $signed({2'b00, ld_major, 1'b0});
      decision_term          <= $signed({2'b00, ld_minor, 1'b0})
                                - $signed({3'b000, ld_major});
    end else if (emit && !is_last) begin
      pos_x <= pos_x + coord_t'(x_inc);
      if (y_step) begin
        pos_y <= pos_y_next;
      end
      if (d_neg) begin
        decision_term <= decision_term + $signed({1'b0, twice_minor});
      end else begin
        decision_term <= decision_term + twice_minor_less_major;
      end
    end
  end

  // Output stage: fill on emit, drain on acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x     <= pos_x;
      pixel_y     <= pos_y;
      pixel_color <= held_color;
      last_pixel  <= is_last;
    end
  end

endmodule

>>> design/line_rasterizer.sv
// ----------------------------------------------------------------------------
// line_rasterizer
// Bresenham line generator: a start request loads a line, each step request
// emits the next pixel, if a line is active, with colour and final-pixel flag.
// ----------------------------------------------------------------------------
// A step request is stored in the request queue, and its pixel is then held
// in the output register until accepted.
// Throughput: one request per cycle unless output stalls fill the queue.
// Reset: synchronous; clears the queue, the active-line flag and out_valid.
// The 4-entry request queue lets input accept while output is stalled.
module line_rasterizer import lrast_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   start_req,
  input  coord_t x_begin,
  input  coord_t y_begin,
  input  coord_t x_finish,
  input  coord_t y_finish,
  input  color_t line_color,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t pixel_x,
  output coord_t pixel_y,
  output color_t pixel_color,
  output logic   last_pixel
);

  lrast_cmd_t front_cmd, queue_cmd;
  logic       queue_valid, queue_pop;

  // Classify and order endpoints
  lrast_front u_front (
    .start_req  (start_req),
    .x_begin    (x_begin),
    .y_begin    (y_begin),
    .x_finish   (x_finish),
    .y_finish   (y_finish),
    .line_color (line_color),
    .cmd        (front_cmd)
  );

  // Buffer requests between front and stepper
  lrast_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready),
    .push_data (front_cmd),
    .not_full  (in_ready),
    .pop       (queue_pop),
    .not_empty (queue_valid),
    .pop_data  (queue_cmd)
  );

  // Step lines and emit pixels
  lrast_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (queue_valid),
    .cmd         (queue_cmd),
    .cmd_pop     (queue_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last_pixel  (last_pixel)
  );

endmodule

>>> tb/line_rasterizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer_tb
// Self-checking bench for the Bresenham line generator. A table of directed
// requests covers single points, reversed spans, the screen corners and
// abandoned lines. A random mix of short lines, long lines cut off early and
// stray step ticks follows. Every emitted pixel is checked against a local
// line tracer, with random gaps on the request side and random stalls on the
// pixel side.
// ----------------------------------------------------------------------------
module line_rasterizer_tb;
  import lrast_pkg::*;

  localparam logic REQ_START = 1'b1;
  localparam logic REQ_STEP  = 1'b0;
  localparam int   MAX_COORD = (1 << COORD_BITS) - 1;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t c;
    logic   last;
  } pixel_t;

  // One request, plus the pixel it must yield where that is known by hand
  typedef struct packed {
    logic   start;
    coord_t xa;
    coord_t ya;
    coord_t xb;
    coord_t yb;
    color_t col;
    logic   typed;
    logic   due;
    coord_t ex;
    coord_t ey;
    color_t ec;
    logic   el;
  } vector_t;

  logic   clk        = 1'b0;
  logic   rst        = 1'b1;
  logic   in_valid   = 1'b0;
  logic   in_ready;
  logic   start_req  = REQ_STEP;
  coord_t x_begin    = '0;
  coord_t y_begin    = '0;
  coord_t x_finish   = '0;
  coord_t y_finish   = '0;
  color_t line_color = '0;
  logic   out_valid;
  logic   out_ready  = 1'b0;
  coord_t pixel_x;
  coord_t pixel_y;
  color_t pixel_color;
  logic   last_pixel;

  // Line tracer state
  logic                         pen_on;
  coord_t                       pen_x, pen_y, stop_x, stop_y;
  logic signed [ERR_BITS-1:0]   err_acc, err_inc_diag;
  logic        [TWICE_BITS-1:0] err_inc_flat;
  logic                         y_major, y_down;
  color_t                       pen_color;

  pixel_t pixels_due[$];
  int     n_errors   = 0;
  int     n_lines    = 0;
  int     n_requests = 0;
  int     n_pixels   = 0;
  bit     steady     = 1'b0;

  vector_t directed [0:24] = '{
    // step while idle after reset: nothing comes out
    '{REQ_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    16'hFFFF,
      1'b1, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    // single point
    '{REQ_START, 11'd5,    11'd7,    11'd5,    11'd7,    16'h0000,
      1'b0, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{REQ_STEP,  11'd1,    11'd2,    11'd3,    11'd4,    16'h1234,
      1'b1, 1'b1, 11'd5,    11'd7,    16'h0000, 1'b1},
    '{REQ_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    16'h0000,
      1'b1, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    // full-screen diagonal, given in reverse, abandoned after two pixels
    '{REQ_START, 11'd2047, 11'd2047, 11'd0,    11'd0,    16'hFFFF,
      1'b0, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{REQ_STEP,  11'd2047, 11'd2047, 11'd2047, 11'd2047, 16'h0000,
      1'b1, 1'b1, 11'd0,    11'd0,    16'hFFFF, 1'b0},
    '{REQ_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    16'h0000,
      1'b0, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    // vertical line with y reversed
    '{REQ_START, 11'd10,   11'd20,   11'd10,   11'd15,   16'hF800,
      1'b0, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{REQ_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    16'h0000,
      1'b1, 1'b1, 11'd10,   11'd15,   16'hF800, 1'b0},
    '{REQ_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    16'h0000,
      1'b0, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    // horizontal line at the right edge, given in reverse
    '{REQ_START, 11'd2047, 11'd100,  11'd2044, 11'd100,  16'h07E0,
      1'b0, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{REQ_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    16'h0000,
      1'b1, 1'b1, 11'd2044, 11'd100,  16'h07E0, 1'b0},
    '{REQ_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    16'hFFFF,
      1'b0, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{REQ_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    16'h0000,
      1'b0, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{REQ_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    16'h0000,
      1'b0, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    // steep line with y going down from the bottom edge
    '{REQ_START, 11'd0,    11'd2047, 11'd2,    11'd2042, 16'h001F,
      1'b0, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{REQ_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    16'h0000,
      1'b1, 1'b1, 11'd0,    11'd2047, 16'h001F, 1'b0},
    '{REQ_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    16'h0000,
      1'b0, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{REQ_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    16'h0000,
      1'b0, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{REQ_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    16'h0000,
      1'b0, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{REQ_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    16'h0000,
      1'b0, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{REQ_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    16'h0000,
      1'b0, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    // shallow line with y going down, abandoned by the random part
    '{REQ_START, 11'd0,    11'd10,   11'd7,    11'd6,    16'hA5A5,
      1'b0, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{REQ_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    16'h0000,
      1'b1, 1'b1, 11'd0,    11'd10,   16'hA5A5, 1'b0},
    '{REQ_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    16'h0000,
      1'b0, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0}
  };

  line_rasterizer u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .start_req   (start_req),
    .x_begin     (x_begin),
    .y_begin     (y_begin),
    .x_finish    (x_finish),
    .y_finish    (y_finish),
    .line_color  (line_color),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last_pixel  (last_pixel)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    n_errors++;
  endtask

  // Advance the tracer by one request; return 1 when a pixel comes out
  function automatic bit rasterize_request(input vector_t v, output pixel_t pix);
    coord_t xa, ya, xb, yb, dx, dy, major, minor;
    bit     done;
    pix = '0;
    if (v.start == REQ_START) begin
      xa = v.xa;
      ya = v.ya;
      xb = v.xb;
      yb = v.yb;
      // order endpoints so x grows, and y grows on a vertical line
      if (xa > xb || (xa == xb && ya > yb)) begin
        xa = v.xb;
        ya = v.yb;
        xb = v.xa;
        yb = v.ya;
      end
      dx = xb - xa;
      y_down = yb < ya;
      dy = y_down ? ya - yb : yb - ya;
      y_major = dy > dx;
      major = y_major ? dy : dx;
      minor = y_major ? dx : dy;
      pen_x = xa;
      pen_y = ya;
      stop_x = xb;
      stop_y = yb;
      err_inc_flat = TWICE_BITS'(2 * int'(minor));
      err_inc_diag = ERR_BITS'(2 * (int'(minor) - int'(major)));
      err_acc = ERR_BITS'(2 * int'(minor) - int'(major));
      pen_color = v.col;
      pen_on = 1'b1;
      return 1'b0;
    end
    if (!pen_on) return 1'b0;
    done = y_major ? (pen_y == stop_y) : (pen_x == stop_x);
    pix = '{pen_x, pen_y, pen_color, done};
    if (done) begin
      pen_on = 1'b0;
      return 1'b1;
    end
    // step the major axis, then the minor axis when the error term allows
    if (y_major) pen_y = y_down ? pen_y - 1'b1 : pen_y + 1'b1;
    else pen_x = pen_x + 1'b1;
    if (err_acc < 0) begin
      err_acc = ERR_BITS'(int'(err_acc) + int'(err_inc_flat));
    end else begin
      if (y_major) pen_x = pen_x + 1'b1;
      else pen_y = y_down ? pen_y - 1'b1 : pen_y + 1'b1;
      err_acc = ERR_BITS'(int'(err_acc) + int'(err_inc_diag));
    end
    return 1'b1;
  endfunction

  // Drive one request, hold it until accepted, then record its pixel
  task automatic issue(input vector_t v);
    pixel_t pix;
    pixel_t typed_pix;
    bit     got;
    while (!steady && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    start_req  <= v.start;
    x_begin    <= v.xa;
    y_begin    <= v.ya;
    x_finish   <= v.xb;
    y_finish   <= v.yb;
    line_color <= v.col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_requests++;
    if (v.start == REQ_START) n_lines++;
    got = rasterize_request(v, pix);
    if (v.typed) begin
      typed_pix = '{v.ex, v.ey, v.ec, v.el};
      if (got != v.due || (got && pix != typed_pix))
        report_mismatch($sformatf("tracer disagrees with directed request %0d", n_requests));
      if (v.due) pixels_due.push_back(typed_pix);
    end else if (got) begin
      pixels_due.push_back(pix);
    end
  endtask

  function automatic coord_t clamp_coord(input int c);
    if (c < 0) return '0;
    if (c > MAX_COORD) return coord_t'(MAX_COORD);
    return coord_t'(c);
  endfunction

  // Stall the pixel side at random, except during the steady stretch
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 34);
  end

  // Compare each accepted pixel with the oldest one due
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (!rst && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel (%0d,%0d)", pixel_x, pixel_y));
      end else begin
        want = pixels_due.pop_front();
        n_pixels++;
        if (pixel_x !== want.x)
          report_mismatch($sformatf("pixel_x %0d, want %0d", pixel_x, want.x));
        if (pixel_y !== want.y)
          report_mismatch($sformatf("pixel_y %0d, want %0d", pixel_y, want.y));
        if (pixel_color !== want.c)
          report_mismatch($sformatf("pixel_color %h, want %h", pixel_color, want.c));
        if (last_pixel !== want.last)
          report_mismatch($sformatf("last_pixel %b, want %b", last_pixel, want.last));
      end
    end
  end

  initial begin : stimulus
    vector_t v;
    int      n_done;
    int      shape, x0, y0, ddx, ddy, len, steps, drain;
    pen_on = 1'b0;
    pen_x = '0;
    pen_y = '0;
    stop_x = '0;
    stop_y = '0;
    err_acc = '0;
    err_inc_flat = '0;
    err_inc_diag = '0;
    y_major = 1'b0;
    y_down = 1'b0;
    pen_color = '0;
    n_done = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) issue(directed[i]);

    // Random lines: mostly short, some full-screen lines cut off early
    while (n_done < 925) begin
      steady = (n_done >= 300 && n_done < 550);
      v = '0;
      v.start = REQ_START;
      v.col = color_t'($urandom);
      shape = $urandom_range(99);
      if (shape < 8) begin
        v.xa = coord_t'($urandom);
        v.ya = coord_t'($urandom);
        v.xb = coord_t'($urandom);
        v.yb = coord_t'($urandom);
      end else begin
        x0 = ($urandom_range(9) == 0) ? MAX_COORD * $urandom_range(1) : $urandom_range(MAX_COORD);
        y0 = ($urandom_range(9) == 0) ? MAX_COORD * $urandom_range(1) : $urandom_range(MAX_COORD);
        ddx = $urandom_range(30) - 15;
        ddy = $urandom_range(30) - 15;
        // force flat, upright and 45-degree runs now and then
        case ($urandom_range(5))
          0: ddy = 0;
          1: ddx = 0;
          2: ddy = ($urandom_range(1) != 0) ? ddx : -ddx;
          default: ;
        endcase
        v.xa = clamp_coord(x0);
        v.ya = clamp_coord(y0);
        v.xb = clamp_coord(x0 + ddx);
        v.yb = clamp_coord(y0 + ddy);
      end
      issue(v);
      n_done++;

      ddx = (v.xb > v.xa) ? v.xb - v.xa : v.xa - v.xb;
      ddy = (v.yb > v.ya) ? v.yb - v.ya : v.ya - v.yb;
      len = ((ddx > ddy) ? ddx : ddy) + 1;
      if (len > 48) steps = $urandom_range(48, 1);
      else if ($urandom_range(99) < 85) steps = len + $urandom_range(2);
      else steps = $urandom_range(len);

      for (int k = 0; k < steps; k++) begin
        v.start = REQ_STEP;
        v.xa = coord_t'($urandom);
        v.ya = coord_t'($urandom);
        v.xb = coord_t'($urandom);
        v.yb = coord_t'($urandom);
        v.col = color_t'($urandom);
        issue(v);
        n_done++;
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // Drain the pixels still due, then allow the pipeline to settle
    drain = 0;
    while (pixels_due.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (pixels_due.size() != 0)
      report_mismatch($sformatf("%0d pixels never emitted", pixels_due.size()));

    $display("Covered %0d requests over %0d lines; %0d pixels compared, %0d mismatches.",
             n_requests, n_lines, n_pixels, n_errors);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("Run did not finish in time.");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
